// ===== sv/trv_pkg.sv =====
// Shared constants and types for the Trivium keystream cipher.
// Used by trv_cell, trv_rounds and trivium_stream_cipher; depends on nothing.
package trv_pkg;

  // State layout: three shift registers packed into one 288-bit vector (0-based).
  localparam int StateBits = 288;
  localparam int RegAStart = 0;
  localparam int RegBStart = 93;
  localparam int RegCStart = 177;
  localparam int KeyBits   = 80;

  // Eight rounds are evaluated per clock cycle in which the state advances.
  localparam int RoundsPerCycle = 8;
  localparam int WarmupRounds   = 1152;
  localparam int WarmupCycles   = WarmupRounds / RoundsPerCycle;
  localparam int WarmCntW       = $clog2(WarmupCycles + 1);

  // Tap positions for round zero (0-based state indexes).
  localparam int TapAOut  = 65;
  localparam int TapAFwd  = 68;
  localparam int TapAAnd0 = 90;
  localparam int TapAAnd1 = 91;
  localparam int TapALast = 92;
  localparam int TapBOut  = 161;
  localparam int TapBFwd  = 170;
  localparam int TapBAnd0 = 174;
  localparam int TapBAnd1 = 175;
  localparam int TapBLast = 176;
  localparam int TapCOut  = 242;
  localparam int TapCFwd  = 263;
  localparam int TapCAnd0 = 285;
  localparam int TapCAnd1 = 286;
  localparam int TapCLast = 287;

  // Configuration register indexes.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] CfgKeyUpper = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLower = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIvUpper  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIvLower  = 3'd3;

  // Input command codes.
  localparam logic CmdData    = 1'b0;
  localparam logic CmdRestart = 1'b1;

  // Control shared by every state cell.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/trivium_stream_cipher.sv =====
// Top level of the Trivium keystream cipher: configuration registers, the row
// of state cells, warm-up control and the output buffer. Depends on trv_pkg.
//
// In a data transaction the state advances eight rounds per clock through a
// row of 288 one-bit cells, and the byte is XORed with the eight keystream
// bits of those rounds. A restart transaction loads key and IV from the
// configuration registers and then runs the warm-up (1152 rounds at eight
// rounds a cycle); the input stalls until the warm-up is done.
// Results wait in a two-entry output buffer, so input keeps flowing while one
// result is held up. Bytes before the first restart pass through unchanged.
// Configuration writes are taken in any cycle and are read at the next restart.
module trivium_stream_cipher (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [7:0]                   data_byte_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  // Configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [trv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trv_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int N  = trv_pkg::StateBits;
  localparam int R  = trv_pkg::RoundsPerCycle;
  localparam int KB = trv_pkg::KeyBits;

  // Configuration registers.
  logic [15:0] key_upper_q, iv_upper_q;
  logic [63:0] key_lower_q, iv_lower_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
      iv_upper_q  <= '0;
      iv_lower_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        trv_pkg::CfgKeyUpper: key_upper_q <= cfg_data_i[15:0];
        trv_pkg::CfgKeyLower: key_lower_q <= cfg_data_i;
        trv_pkg::CfgIvUpper:  iv_upper_q  <= cfg_data_i[15:0];
        trv_pkg::CfgIvLower:  iv_lower_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [KB-1:0] key80, iv80;
  assign key80 = {key_upper_q, key_lower_q};
  assign iv80  = {iv_upper_q, iv_lower_q};

  // Control state.
  logic [trv_pkg::WarmCntW-1:0] warm_cnt_d, warm_cnt_q;
  logic                         keyed_d, keyed_q;
  logic                         busy;
  logic [1:0]                   fill_d, fill_q;
  logic [7:0]                   obuf_d [2];
  logic [7:0]                   obuf_q [2];

  logic in_accept, restart, data_go, pop;
  trv_pkg::cell_ctrl_t cell_ctrl;

  assign busy       = (warm_cnt_q != '0);
  assign in_stall_o = busy || (fill_q == 2'd2);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign restart    = in_accept && (command_i == trv_pkg::CmdRestart);
  assign data_go    = in_accept && (command_i == trv_pkg::CmdData);

  assign cell_ctrl.load  = restart;
  assign cell_ctrl.shift = busy || (data_go && keyed_q);

  // State cells and the eight-round feedback.
  logic [N-1:0] st, load_vec, shift_vec;
  logic [R-1:0] t1, t2, t3, ks;

  trv_rounds u_rounds (
    .state_i (st),
    .t1_o    (t1),
    .t2_o    (t2),
    .t3_o    (t3),
    .ks_o    (ks)
  );

  // Each cell takes the bit eight places behind it; the first eight cells of a
  // register take the new feedback bits, the latest round at the front.
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i < trv_pkg::RegAStart + R) begin : g_fa
      assign shift_vec[i] = t3[R-1-(i-trv_pkg::RegAStart)];
    end else if (i >= trv_pkg::RegBStart && i < trv_pkg::RegBStart + R) begin : g_fb
      assign shift_vec[i] = t1[R-1-(i-trv_pkg::RegBStart)];
    end else if (i >= trv_pkg::RegCStart && i < trv_pkg::RegCStart + R) begin : g_fc
      assign shift_vec[i] = t2[R-1-(i-trv_pkg::RegCStart)];
    end else begin : g_nb
      assign shift_vec[i] = st[i-R];
    end

    // Key in the first register, IV in the second, ones in the last three bits.
    if (i < KB) begin : g_lk
      assign load_vec[i] = key80[KB-1-i];
    end else if (i >= trv_pkg::RegBStart && i < trv_pkg::RegBStart + KB) begin : g_li
      assign load_vec[i] = iv80[KB-1-(i-trv_pkg::RegBStart)];
    end else if (i >= N - 3) begin : g_l1
      assign load_vec[i] = 1'b1;
    end else begin : g_l0
      assign load_vec[i] = 1'b0;
    end

    trv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .load_bit_i  (load_vec[i]),
      .shift_bit_i (shift_vec[i]),
      .bit_o       (st[i])
    );
  end

  // Warm-up counter and the keyed flag.
  always_comb begin
    warm_cnt_d = warm_cnt_q;
    keyed_d    = keyed_q;
    if (restart) begin
      warm_cnt_d = trv_pkg::WarmCntW'(trv_pkg::WarmupCycles);
      keyed_d    = 1'b1;
    end else if (busy) begin
      warm_cnt_d = warm_cnt_q - 1'b1;
    end
  end

  // Two-entry output buffer; the head is entry zero.
  logic [7:0] result;
  logic       wr_idx;

  assign result      = keyed_q ? (data_byte_i ^ ks) : data_byte_i;
  assign out_valid_o = (fill_q != 2'd0);
  assign out_byte_o  = obuf_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  // A new result goes behind the entries that remain after this cycle's pop.
  assign wr_idx      = fill_q[0] & ~pop;

  always_comb begin
    obuf_d = obuf_q;
    fill_d = fill_q;
    if (pop) begin
      obuf_d[0] = obuf_q[1];
    end
    if (data_go) begin
      obuf_d[wr_idx] = result;
    end
    fill_d = fill_q + {1'b0, data_go} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_cnt_q <= '0;
      keyed_q    <= 1'b0;
      fill_q     <= 2'd0;
    end else begin
      warm_cnt_q <= warm_cnt_d;
      keyed_q    <= keyed_d;
      fill_q     <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

  // A restart loads the three set bits of the last register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> (st[N-1:N-3] == 3'b111))
    else $error("restart did not load the constant ones");

  // Warm-up counts down by one each cycle until it is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !restart) |=> (warm_cnt_q == $past(warm_cnt_q) - 1'b1))
    else $error("warm-up counter skipped");

  // The output buffer never holds more than two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("output buffer overflow");

  // No result is produced while warm-up runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (fill_q <= $past(fill_q)))
    else $error("result pushed during warm-up");

endmodule

// ===== sv/trv_cell.sv =====
// One bit of the cipher state: loads from the key/IV layout or takes its shift
// input bit when the state advances. Depends on trv_pkg.
module trv_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trv_pkg::cell_ctrl_t ctrl_i,
  input  logic                load_bit_i,
  input  logic                shift_bit_i,
  output logic                bit_o
);

  logic bit_d, bit_q;

  // Load has priority; otherwise advance or hold.
  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.load) begin
      bit_d = load_bit_i;
    end else if (ctrl_i.shift) begin
      bit_d = shift_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

// ===== sv/trv_rounds.sv =====
// Feedback and keystream logic for eight consecutive rounds.
// Depends on trv_pkg for the tap positions.
module trv_rounds (
  input  logic [trv_pkg::StateBits-1:0]      state_i,
  output logic [trv_pkg::RoundsPerCycle-1:0] t1_o,
  output logic [trv_pkg::RoundsPerCycle-1:0] t2_o,
  output logic [trv_pkg::RoundsPerCycle-1:0] t3_o,
  output logic [trv_pkg::RoundsPerCycle-1:0] ks_o
);

  // Within eight rounds no tap reaches a freshly inserted bit, so round k simply
  // reads every tap k positions earlier in the current state.
  always_comb begin
    logic a, b, c;
    for (int k = 0; k < trv_pkg::RoundsPerCycle; k++) begin
      a = state_i[trv_pkg::TapAOut - k] ^ state_i[trv_pkg::TapALast - k];
      b = state_i[trv_pkg::TapBOut - k] ^ state_i[trv_pkg::TapBLast - k];
      c = state_i[trv_pkg::TapCOut - k] ^ state_i[trv_pkg::TapCLast - k];
      // The first round's keystream bit lands at the MSB.
      ks_o[trv_pkg::RoundsPerCycle-1-k] = a ^ b ^ c;
      t1_o[k] = a ^ (state_i[trv_pkg::TapAAnd0 - k] & state_i[trv_pkg::TapAAnd1 - k])
                  ^ state_i[trv_pkg::TapBFwd - k];
      t2_o[k] = b ^ (state_i[trv_pkg::TapBAnd0 - k] & state_i[trv_pkg::TapBAnd1 - k])
                  ^ state_i[trv_pkg::TapCFwd - k];
      t3_o[k] = c ^ (state_i[trv_pkg::TapCAnd0 - k] & state_i[trv_pkg::TapCAnd1 - k])
                  ^ state_i[trv_pkg::TapAFwd - k];
    end
  end

endmodule
